### rtl/core/sequence_read_quality_stats_core_macros.svh
// assertion helpers for the read quality statistics core
`ifndef SEQUENCE_READ_QUALITY_STATS_CORE_MACROS_SVH
`define SEQUENCE_READ_QUALITY_STATS_CORE_MACROS_SVH

// condition that holds at every clock edge out of reset
`define SQS_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// implication checked in the same cycle
`define SQS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

### rtl/core/sqs_pkg.sv
package sqs_pkg;

  // result kinds
  typedef enum logic [2:0] {
    KIND_BASE    = 3'd0,
    KIND_DONE    = 3'd1,
    KIND_BAD     = 3'd2,
    KIND_LONG    = 3'd3,
    KIND_READOUT = 3'd4
  } sqs_kind_e;

  // base classes
  typedef enum logic [2:0] {
    BASE_A,
    BASE_T,
    BASE_G,
    BASE_C,
    BASE_N,
    BASE_BAD
  } sqs_base_e;

  // controller states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_UPD,
    ST_DIV,
    ST_FIN
  } sqs_state_e;

  // controller commands
  typedef struct packed {
    logic clear;
    logic accept;
    logic square;
    logic update;
    logic load_out;
  } sqs_cmd_t;

  // datapath status
  typedef struct packed {
    logic clr_last;
    logic readout;
    logic drop;
    logic last;
    logic div_busy;
    logic out_free;
  } sqs_stat_t;

  // one entry of the per-cycle store
  typedef struct packed {
    logic [31:0] cnt_a;
    logic [31:0] cnt_t;
    logic [31:0] cnt_g;
    logic [31:0] cnt_c;
    logic [31:0] cnt_n;
    logic [62:0] err_sum;
    logic [62:0] err_sq_sum;
  } sqs_word_t;

  localparam logic [7:0] CH_A = 8'h41;
  localparam logic [7:0] CH_T = 8'h54;
  localparam logic [7:0] CH_G = 8'h47;
  localparam logic [7:0] CH_C = 8'h43;
  localparam logic [7:0] CH_N = 8'h4e;
  localparam logic [7:0] CH_LOWER = 8'h20;

  localparam logic [6:0]  OFFSET_RESET = 7'd33;
  localparam logic [31:0] ONE_Q31 = 32'h8000_0000;
  localparam logic [62:0] SAT63 = {63{1'b1}};
  localparam int          ROM_N = 100;
  localparam logic [63:0] DEC16 = 64'd10000000000000000;

  localparam logic [9:0][63:0] TENTH_POW = {
    64'd1258925411794167, 64'd1584893192461113, 64'd1995262314968880,
    64'd2511886431509580, 64'd3162277660168379, 64'd3981071705534972,
    64'd5011872336272722, 64'd6309573444801932, 64'd7943282347242815,
    64'd10000000000000000
  };

  // error rate of one quality step, worked out at elaboration
  function automatic logic [31:0] err_rom_f(input int d);
    logic [63:0] r;
    logic [63:0] v;
    logic [63:0] dv;
    logic [63:0] num;
    logic [63:0] rem;
    logic [63:0] quo;
    int          q;
    int          k;
    q = d / 10;
    k = d % 10;
    if (q >= 10) begin
      return 32'd0;
    end
    r = TENTH_POW[k];
    v = 64'd0;
    if (r >= DEC16) begin
      v = 64'd1;
      r = r - DEC16;
    end
    for (int i = 0; i < 54; i++) begin
      r = r << 1;
      v = v << 1;
      if (r >= DEC16) begin
        r = r - DEC16;
        v = v | 64'd1;
      end
    end
    dv = 64'd1;
    for (int i = 0; i < q; i++) begin
      dv = dv * 64'd10;
    end
    dv  = dv << 23;
    num = v + (dv >> 1);
    rem = 64'd0;
    quo = 64'd0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      if (rem >= dv) begin
        rem    = rem - dv;
        quo[i] = 1'b1;
      end
    end
    return quo[31:0];
  endfunction

  function automatic logic [ROM_N-1:0][31:0] build_rom_f();
    logic [ROM_N-1:0][31:0] t;
    for (int i = 0; i < ROM_N; i++) begin
      t[i] = err_rom_f(i);
    end
    return t;
  endfunction

  localparam logic [ROM_N-1:0][31:0] ERR_ROM = build_rom_f();

  // quality rank of an error rate
  function automatic logic [1:0] rank_f(input logic [31:0] e);
    logic [1:0] r;
    if (e <= ERR_ROM[30]) r = 2'd3;
    else if (e <= ERR_ROM[20]) r = 2'd2;
    else if (e <= ERR_ROM[10]) r = 2'd1;
    else r = 2'd0;
    return r;
  endfunction

endpackage

### rtl/core/sqs_div.sv
module sqs_div #(
  parameter int NUM_W = 43,
  parameter int DEN_W = 12
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             busy_o,
  output logic [31:0]      quot_o
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [NUM_W-1:0] num_q, num_d;
  logic [DEN_W:0]   rem_q, rem_d;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W:0]   rem_sh;

  // one quotient bit per cycle, restoring
  always_comb begin
    cnt_d  = cnt_q;
    num_d  = num_q;
    rem_d  = rem_q;
    rem_sh = {rem_q[DEN_W-1:0], num_q[NUM_W-1]};
    if (start_i) begin
      cnt_d = CNT_W'(NUM_W);
      num_d = num_i;
      rem_d = '0;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
      if (rem_sh >= {1'b0, den_q}) begin
        rem_d = rem_sh - {1'b0, den_q};
        num_d = {num_q[NUM_W-2:0], 1'b1};
      end else begin
        rem_d = rem_sh;
        num_d = {num_q[NUM_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign busy_o = (cnt_q != '0);
  assign quot_o = num_q[31:0];

endmodule

### rtl/core/sqs_ctrl.sv
module sqs_ctrl
  import sqs_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  sqs_stat_t stat_i,
  output logic      in_ready_o,
  output sqs_cmd_t  cmd_o
);

  sqs_state_e state_q, state_d;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (stat_i.clr_last) state_d = ST_IDLE;
      ST_IDLE:  if (in_valid_i) state_d = ST_LOOK;
      ST_LOOK: begin
        if (stat_i.readout || stat_i.drop) state_d = ST_FIN;
        else state_d = ST_UPD;
      end
      ST_UPD: begin
        if (stat_i.last) state_d = ST_DIV;
        else state_d = ST_FIN;
      end
      ST_DIV:   if (!stat_i.div_busy) state_d = ST_FIN;
      ST_FIN:   if (stat_i.out_free) state_d = ST_IDLE;
      default:  state_d = ST_CLEAR;
    endcase
  end

  // commands
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_CLEAR: cmd_o.clear = 1'b1;
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      ST_LOOK:  cmd_o.square = 1'b1;
      ST_UPD:   cmd_o.update = 1'b1;
      ST_DIV:   cmd_o = '0;
      ST_FIN:   cmd_o.load_out = stat_i.out_free;
      default:  cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### rtl/core/sqs_datapath.sv
`include "sequence_read_quality_stats_core_macros.svh"

module sqs_datapath
  import sqs_pkg::*;
#(
  parameter int MAX_CYCLES = 2048
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  sqs_cmd_t    cmd_i,
  output sqs_stat_t   stat_o,
  input  logic        cfg_we_i,
  input  logic [6:0]  cfg_data_i,
  input  logic        opcode_i,
  input  logic [7:0]  base_char_i,
  input  logic [7:0]  quality_char_i,
  input  logic        last_base_i,
  input  logic [10:0] cycle_index_i,
  input  logic        out_ready_i,
  output logic        out_valid_o,
  output logic [2:0]  result_kind_o,
  output logic [11:0] read_length_o,
  output logic [31:0] read_error_mean_o,
  output logic [1:0]  read_rank_o,
  output logic [1:0]  base_rank_o,
  output logic [31:0] count_a_o,
  output logic [31:0] count_t_o,
  output logic [31:0] count_g_o,
  output logic [31:0] count_c_o,
  output logic [31:0] count_n_o,
  output logic [62:0] cycle_error_sum_o,
  output logic [62:0] cycle_error_sq_sum_o
);

  localparam int POS_W  = $clog2(MAX_CYCLES + 1);
  localparam int ADDR_W = $clog2(MAX_CYCLES);
  localparam int ACC_W  = 31 + POS_W;

  // control registers
  logic [6:0]       offset_q;
  logic [POS_W-1:0] pos_q, clr_cnt_q;
  logic             drop_q;
  logic             out_valid_q;
  logic             op_q, dropit_q, last_q;

  // payload registers
  logic [ACC_W-1:0] acc_q;
  logic [POS_W-1:0] len_q;
  sqs_kind_e        kind_q;
  sqs_base_e        base_q;
  logic [31:0]      e_q;
  logic [63:0]      prod_q;
  logic             idx_ok_q;
  sqs_word_t        rdata_q;

  sqs_word_t        mem_q [MAX_CYCLES];

  sqs_base_e        base_cls;
  logic             at_max;
  logic             drop_now;
  logic signed [9:0] d_val;
  logic [31:0]      e_lut;
  logic [ADDR_W-1:0] raddr;
  logic             mem_we;
  logic [ADDR_W-1:0] waddr;
  sqs_word_t        wdata;
  logic [63:0]      sq_full;
  logic [ACC_W-1:0] acc_new;
  logic [POS_W-1:0] pos_new;
  logic             div_busy;
  logic [31:0]      mean;

  function automatic logic [62:0] sat_add63(input logic [62:0] p, input logic [63:0] v);
    logic [63:0] s;
    s = {1'b0, p} + v;
    return (s >= {1'b0, SAT63}) ? SAT63 : s[62:0];
  endfunction

  function automatic logic [31:0] inc32(input logic [31:0] c);
    return (c == '1) ? c : c + 32'd1;
  endfunction

  // base letter class, either case
  always_comb begin
    case (base_char_i | CH_LOWER)
      (CH_A | CH_LOWER): base_cls = BASE_A;
      (CH_T | CH_LOWER): base_cls = BASE_T;
      (CH_G | CH_LOWER): base_cls = BASE_G;
      (CH_C | CH_LOWER): base_cls = BASE_C;
      (CH_N | CH_LOWER): base_cls = BASE_N;
      default:           base_cls = BASE_BAD;
    endcase
  end

  // quality to error rate
  always_comb begin
    d_val = $signed({2'b00, quality_char_i}) - $signed({3'b000, offset_q});
    if (d_val[9]) e_lut = ONE_Q31;
    else if (d_val[8:0] >= 9'd100) e_lut = 32'd0;
    else e_lut = ERR_ROM[d_val[6:0]];
  end

  assign at_max   = (pos_q >= POS_W'(MAX_CYCLES));
  assign drop_now = drop_q || at_max || (base_cls == BASE_BAD);
  assign raddr    = opcode_i ? ADDR_W'(cycle_index_i) : pos_q[ADDR_W-1:0];

  // read update values
  assign sq_full = (prod_q + 64'h0000_0000_4000_0000) >> 31;
  assign acc_new = acc_q + ACC_W'(e_q);
  assign pos_new = pos_q + 1'b1;

  // store write: clearing pass or read-modify-write
  always_comb begin
    mem_we = cmd_i.clear || cmd_i.update;
    wdata  = '0;
    waddr  = clr_cnt_q[ADDR_W-1:0];
    if (!cmd_i.clear) begin
      waddr            = pos_q[ADDR_W-1:0];
      wdata            = rdata_q;
      wdata.err_sum    = sat_add63(rdata_q.err_sum, {32'd0, e_q});
      wdata.err_sq_sum = sat_add63(rdata_q.err_sq_sum, sq_full);
      case (base_q)
        BASE_A:  wdata.cnt_a = inc32(rdata_q.cnt_a);
        BASE_T:  wdata.cnt_t = inc32(rdata_q.cnt_t);
        BASE_G:  wdata.cnt_g = inc32(rdata_q.cnt_g);
        BASE_C:  wdata.cnt_c = inc32(rdata_q.cnt_c);
        BASE_N:  wdata.cnt_n = inc32(rdata_q.cnt_n);
        default: wdata.cnt_n = rdata_q.cnt_n;
      endcase
    end
  end

  // per-cycle store
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[waddr] <= wdata;
    end
    if (cmd_i.accept) begin
      rdata_q <= mem_q[raddr];
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q    <= OFFSET_RESET;
      pos_q       <= '0;
      drop_q      <= 1'b0;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
      op_q        <= 1'b0;
      dropit_q    <= 1'b0;
      last_q      <= 1'b0;
      acc_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        offset_q <= cfg_data_i;
      end
      if (cmd_i.clear) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
      if (cmd_i.accept) begin
        op_q     <= opcode_i;
        dropit_q <= !opcode_i && drop_now;
        last_q   <= last_base_i;
        if (!opcode_i && drop_now) begin
          drop_q <= !last_base_i;
          if (last_base_i) begin
            pos_q <= '0;
            acc_q <= '0;
          end
        end
      end
      if (cmd_i.update) begin
        if (last_q) begin
          pos_q  <= '0;
          acc_q  <= '0;
          drop_q <= 1'b0;
        end else begin
          pos_q <= pos_new;
          acc_q <= acc_new;
        end
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // item payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      base_q   <= base_cls;
      e_q      <= e_lut;
      idx_ok_q <= (32'(cycle_index_i) < 32'(MAX_CYCLES));
      if (opcode_i) kind_q <= KIND_READOUT;
      else if (drop_now) kind_q <= at_max ? KIND_LONG : KIND_BAD;
      else kind_q <= last_base_i ? KIND_DONE : KIND_BASE;
    end
    if (cmd_i.square) begin
      prod_q <= e_q * e_q;
    end
    if (cmd_i.update) begin
      len_q <= pos_new;
    end
  end

  // mean error of the finished read
  sqs_div #(
    .NUM_W(ACC_W),
    .DEN_W(POS_W)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.update && last_q),
    .num_i  (acc_new + ACC_W'(pos_new >> 1)),
    .den_i  (pos_new),
    .busy_o (div_busy),
    .quot_o (mean)
  );

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      result_kind_o        <= kind_q;
      read_length_o        <= '0;
      read_error_mean_o    <= '0;
      read_rank_o          <= '0;
      base_rank_o          <= '0;
      count_a_o            <= '0;
      count_t_o            <= '0;
      count_g_o            <= '0;
      count_c_o            <= '0;
      count_n_o            <= '0;
      cycle_error_sum_o    <= '0;
      cycle_error_sq_sum_o <= '0;
      if (kind_q == KIND_BASE || kind_q == KIND_DONE) begin
        base_rank_o <= rank_f(e_q);
      end
      if (kind_q == KIND_DONE) begin
        read_length_o     <= 12'(len_q);
        read_error_mean_o <= mean;
        read_rank_o       <= rank_f(mean);
      end
      if (kind_q == KIND_READOUT && idx_ok_q) begin
        count_a_o            <= rdata_q.cnt_a;
        count_t_o            <= rdata_q.cnt_t;
        count_g_o            <= rdata_q.cnt_g;
        count_c_o            <= rdata_q.cnt_c;
        count_n_o            <= rdata_q.cnt_n;
        cycle_error_sum_o    <= rdata_q.err_sum;
        cycle_error_sq_sum_o <= rdata_q.err_sq_sum;
      end
    end
  end

  assign out_valid_o = out_valid_q;

  // status to the controller
  always_comb begin
    stat_o          = '0;
    stat_o.clr_last = (clr_cnt_q == POS_W'(MAX_CYCLES - 1));
    stat_o.readout  = op_q;
    stat_o.drop     = dropit_q;
    stat_o.last     = last_q;
    stat_o.div_busy = div_busy;
    stat_o.out_free = !out_valid_q || out_ready_i;
  end

  `SQS_ASSERT_IMP(a_upd_clean, cmd_i.update, !dropit_q && !op_q, "update on dropped or readout item")
  `SQS_ASSERT(a_pos_bound, pos_q <= POS_W'(MAX_CYCLES), "read position past limit")
  `SQS_ASSERT_IMP(a_mean_ready, cmd_i.load_out && kind_q == KIND_DONE, !div_busy, "mean not ready")

endmodule

### rtl/core/sequence_read_quality_stats_core.sv
// per-cycle quality statistics for sequencing reads
// input channel (in_valid_i/in_ready_o): one item is a base with its
//   quality character and last-of-read mark (opcode 0), or a readout
//   request for one cycle position (opcode 1)
// output channel (out_valid_o/out_ready_i): one result item per input item
// config channel (cfg_valid_i/cfg_ready_o): quality offset, always ready;
//   write it only while the block is idle
// latency: readout or dropped base gives its result 2 cycles after accept,
//   a counted base 3 cycles, a read end 4 + (31 + clog2(MAX_CYCLES+1))
//   cycles, set by the one-bit-per-cycle mean divider
// throughput: one item every 3 cycles (4 for a counted base), limited by the
//   single-port read-modify-write of the per-cycle store
// reset: the store is zeroed by a pass of MAX_CYCLES cycles, one entry per
//   cycle, during which in_ready_o stays low
// stall: a result waits in the output register while the next item is
//   accepted and worked; the block holds only when a new result is ready
//   and the output register is still full
module sequence_read_quality_stats_core
  import sqs_pkg::*;
#(
  parameter int MAX_CYCLES = 2048
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [6:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        opcode_i,
  input  logic [7:0]  base_char_i,
  input  logic [7:0]  quality_char_i,
  input  logic        last_base_i,
  input  logic [10:0] cycle_index_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  result_kind_o,
  output logic [11:0] read_length_o,
  output logic [31:0] read_error_mean_o,
  output logic [1:0]  read_rank_o,
  output logic [1:0]  base_rank_o,
  output logic [31:0] count_a_o,
  output logic [31:0] count_t_o,
  output logic [31:0] count_g_o,
  output logic [31:0] count_c_o,
  output logic [31:0] count_n_o,
  output logic [62:0] cycle_error_sum_o,
  output logic [62:0] cycle_error_sq_sum_o
);

  sqs_cmd_t  cmd;
  sqs_stat_t stat;

  assign cfg_ready_o = 1'b1;

  // sequencer
  sqs_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .stat_i    (stat),
    .in_ready_o(in_ready_o),
    .cmd_o     (cmd)
  );

  // store, arithmetic and result register
  sqs_datapath #(
    .MAX_CYCLES(MAX_CYCLES)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .stat_o              (stat),
    .cfg_we_i            (cfg_valid_i),
    .cfg_data_i          (cfg_data_i),
    .opcode_i            (opcode_i),
    .base_char_i         (base_char_i),
    .quality_char_i      (quality_char_i),
    .last_base_i         (last_base_i),
    .cycle_index_i       (cycle_index_i),
    .out_ready_i         (out_ready_i),
    .out_valid_o         (out_valid_o),
    .result_kind_o       (result_kind_o),
    .read_length_o       (read_length_o),
    .read_error_mean_o   (read_error_mean_o),
    .read_rank_o         (read_rank_o),
    .base_rank_o         (base_rank_o),
    .count_a_o           (count_a_o),
    .count_t_o           (count_t_o),
    .count_g_o           (count_g_o),
    .count_c_o           (count_c_o),
    .count_n_o           (count_n_o),
    .cycle_error_sum_o   (cycle_error_sum_o),
    .cycle_error_sq_sum_o(cycle_error_sq_sum_o)
  );

endmodule
